// ===== rtl/assert_macros.svh =====
// assertion macros shared by the integer literal parser rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`else

`define ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/ilp_pkg.sv =====
// shared types and constants of the integer literal parser
package ilp_pkg;

  localparam int VALUE_BITS = 32;
  localparam int COUNT_W    = 8;

  typedef enum logic [1:0] {
    RX_DEC = 2'd0,
    RX_HEX = 2'd1,
    RX_BIN = 2'd2,
    RX_OCT = 2'd3
  } radix_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       begin_literal;
    logic       end_of_input;
  } item_t;

  typedef struct packed {
    logic                         accepted;
    logic signed [VALUE_BITS-1:0] literal_value;
    logic [COUNT_W-1:0]           chars_used;
    radix_t                       radix_code;
  } result_t;

endpackage

// ===== rtl/ilp_input_stage.sv =====
// input word register of the integer literal parser
module ilp_input_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  ilp_pkg::item_t in_item,
  input  logic           take,
  output logic           q_valid,
  output ilp_pkg::item_t q
);

  logic load;

  // held word blocks only while the parser cannot take it
  assign in_stall = q_valid && !take;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (load) begin
      q_valid <= 1'b1;
    end else if (take) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q <= in_item;
    end
  end

endmodule

// ===== rtl/ilp_step.sv =====
// per-character parse step and literal state registers
`include "assert_macros.svh"

module ilp_step (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  ilp_pkg::item_t   item,
  input  logic             res_ready,
  output logic             take,
  output logic             res_load,
  output ilp_pkg::result_t res
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_START,
    PH_PREFIX,
    PH_ZERO,
    PH_FIRST,
    PH_DIGITS
  } phase_t;

  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [5:0] NO_DIGIT  = 6'h3F;
  localparam logic [ilp_pkg::COUNT_W-1:0] COUNT_MAX = '1;

  phase_t                           phase;
  logic                             negative;
  ilp_pkg::radix_t                  radix;
  logic [ilp_pkg::VALUE_BITS-1:0]   accumulator;
  logic [ilp_pkg::COUNT_W-1:0]      used_count;

  phase_t                           phase_next;
  logic                             negative_next;
  ilp_pkg::radix_t                  radix_next;
  logic [ilp_pkg::VALUE_BITS-1:0]   accumulator_next;
  logic [ilp_pkg::COUNT_W-1:0]      used_count_next;

  logic                             done;
  logic                             emit;
  logic                             ok;
  logic [5:0]                       digit;
  logic [7:0]                       c;
  logic                             eof;

  function automatic logic [5:0] digit_of(input logic [7:0] ch);
    logic [5:0] d;
    d = NO_DIGIT;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      d = 6'(ch - 8'h30);
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      d = 6'(ch - 8'h61 + 8'd10);
    end else if (ch >= 8'h41 && ch <= 8'h5A) begin
      d = 6'(ch - 8'h41 + 8'd10);
    end
    return d;
  endfunction

  function automatic logic fits(input logic [5:0] d, input ilp_pkg::radix_t r);
    logic f;
    case (r)
      ilp_pkg::RX_HEX: f = (d < 6'd16);
      ilp_pkg::RX_BIN: f = (d < 6'd2);
      ilp_pkg::RX_OCT: f = (d < 6'd8);
      default:         f = (d < 6'd10);
    endcase
    return f;
  endfunction

  // times base by shifts, with one add for decimal
  function automatic logic [ilp_pkg::VALUE_BITS-1:0] scale(
    input logic [ilp_pkg::VALUE_BITS-1:0] a,
    input ilp_pkg::radix_t                r
  );
    logic [ilp_pkg::VALUE_BITS-1:0] s;
    case (r)
      ilp_pkg::RX_HEX: s = a << 4;
      ilp_pkg::RX_BIN: s = a << 1;
      ilp_pkg::RX_OCT: s = a << 3;
      default:         s = (a << 3) + (a << 1);
    endcase
    return s;
  endfunction

  function automatic logic [ilp_pkg::COUNT_W-1:0] bump(
    input logic [ilp_pkg::COUNT_W-1:0] n
  );
    return (n == COUNT_MAX) ? n : n + 1'b1;
  endfunction

  assign c     = item.char_code;
  assign eof   = item.end_of_input;
  assign digit = digit_of(c);

  // phases fall through within one character, as far as the digit phases
  always_comb begin
    phase_next       = item.begin_literal ? PH_START : phase;
    negative_next    = item.begin_literal ? 1'b0 : negative;
    radix_next       = item.begin_literal ? ilp_pkg::RX_DEC : radix;
    accumulator_next = item.begin_literal ? '0 : accumulator;
    used_count_next  = item.begin_literal ? '0 : used_count;
    done = 1'b0;
    emit = 1'b0;
    ok   = 1'b0;

    if (phase_next == PH_START) begin
      if (!eof && (c == CH_PLUS || c == CH_MINUS)) begin
        negative_next   = (c == CH_MINUS);
        used_count_next = bump(used_count_next);
        done = 1'b1;
      end
      phase_next = PH_PREFIX;
    end

    if (!done && phase_next == PH_PREFIX) begin
      if (!eof && c == CH_ZERO) begin
        used_count_next = bump(used_count_next);
        phase_next = PH_ZERO;
        done = 1'b1;
      end else begin
        radix_next = ilp_pkg::RX_DEC;
        phase_next = PH_FIRST;
      end
    end

    if (!done && phase_next == PH_ZERO) begin
      if (!eof && (c == CH_X || c == CH_B)) begin
        radix_next      = (c == CH_X) ? ilp_pkg::RX_HEX : ilp_pkg::RX_BIN;
        used_count_next = bump(used_count_next);
        phase_next = PH_FIRST;
        done = 1'b1;
      end else begin
        radix_next = ilp_pkg::RX_OCT;
        phase_next = PH_FIRST;
      end
    end

    if (!done && phase_next == PH_FIRST) begin
      if (!eof && fits(digit, radix_next)) begin
        accumulator_next = ilp_pkg::VALUE_BITS'(digit);
        used_count_next  = bump(used_count_next);
        phase_next = PH_DIGITS;
      end else begin
        // a lone octal zero still counts as a literal
        accumulator_next = '0;
        emit = 1'b1;
        ok   = (radix_next == ilp_pkg::RX_OCT);
        phase_next = PH_IDLE;
      end
      done = 1'b1;
    end

    if (!done && phase_next == PH_DIGITS) begin
      if (!eof && c == CH_USCORE) begin
        used_count_next = bump(used_count_next);
      end else if (!eof && fits(digit, radix_next)) begin
        accumulator_next = scale(accumulator_next, radix_next)
                         + ilp_pkg::VALUE_BITS'(digit);
        used_count_next  = bump(used_count_next);
      end else begin
        emit = 1'b1;
        ok   = 1'b1;
        phase_next = PH_IDLE;
      end
    end
  end

  assign take     = item_valid && (!emit || res_ready);
  assign res_load = item_valid && emit && res_ready;

  always_comb begin
    res.accepted      = ok;
    res.literal_value = '0;
    if (ok) begin
      res.literal_value = negative_next ? -accumulator_next : accumulator_next;
    end
    res.chars_used = used_count_next;
    res.radix_code = radix_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      negative    <= 1'b0;
      radix       <= ilp_pkg::RX_DEC;
      accumulator <= '0;
      used_count  <= '0;
    end else if (take) begin
      phase       <= phase_next;
      negative    <= negative_next;
      radix       <= radix_next;
      accumulator <= accumulator_next;
      used_count  <= used_count_next;
    end
  end

  `ASSERT_IMPL(a_fail_zero, clk, rst, res_load && !res.accepted, res.literal_value == '0)
  `ASSERT_NEXT(a_idle_after_result, clk, rst, res_load, phase == PH_IDLE)

endmodule

// ===== rtl/ilp_result_reg.sv =====
// result register on the output side of the integer literal parser
`include "assert_macros.svh"

module ilp_result_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  ilp_pkg::result_t d,
  output logic             ready,
  input  logic             out_stall,
  output logic             out_valid,
  output ilp_pkg::result_t q
);

  assign ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q <= d;
    end
  end

  `ASSERT_IMPL(a_no_overwrite, clk, rst, out_valid && out_stall, !load)

endmodule

// ===== rtl/integer_literal_parser.sv =====
// top level of the streaming integer literal parser
//
//  channel | signals                                   | direction | handshake
//  --------+-------------------------------------------+-----------+----------------
//  in      | char_code, begin_literal, end_of_input    | to block  | in_valid/in_stall
//  out     | accepted, literal_value, chars_used,      | from block| out_valid/out_stall
//          | radix_code                                |           |
//
// one character word per cycle while no stall is raised; the word that ends a literal
// passes the input register, then the parse step loads its result word into the
// result register; the limit is the single parse step over the state registers
// rst is synchronous: no open literal, both registers empty
// a stalled result holds only a terminating word; other words keep flowing
module integer_literal_parser (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          char_code,
  input  logic                                begin_literal,
  input  logic                                end_of_input,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                accepted,
  output logic signed [ilp_pkg::VALUE_BITS-1:0] literal_value,
  output logic [ilp_pkg::COUNT_W-1:0]         chars_used,
  output logic [1:0]                          radix_code
);

  ilp_pkg::item_t   in_item;
  ilp_pkg::item_t   item_q;
  logic             item_valid;
  logic             take;
  logic             res_load;
  logic             res_ready;
  ilp_pkg::result_t res_d;
  ilp_pkg::result_t res_q;

  // gather the input word
  always_comb begin
    in_item.char_code     = char_code;
    in_item.begin_literal = begin_literal;
    in_item.end_of_input  = end_of_input;
  end

  // input register
  ilp_input_stage u_input (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .take     (take),
    .q_valid  (item_valid),
    .q        (item_q)
  );

  // prefix, sign and digit handling against the open literal state
  ilp_step u_step (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item_q),
    .res_ready  (res_ready),
    .take       (take),
    .res_load   (res_load),
    .res        (res_d)
  );

  // output register, frees as soon as the result word is taken
  ilp_result_reg u_result (
    .clk       (clk),
    .rst       (rst),
    .load      (res_load),
    .d         (res_d),
    .ready     (res_ready),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .q         (res_q)
  );

  assign accepted      = res_q.accepted;
  assign literal_value = res_q.literal_value;
  assign chars_used    = res_q.chars_used;
  assign radix_code    = res_q.radix_code;

endmodule

// ===== tb/integer_literal_parser_checker.sv =====
// checker for the integer literal parser: watches both channels, predicts and compares
`timescale 1ns / 100ps

module integer_literal_parser_checker (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  input  logic                                  in_stall,
  input  logic [7:0]                            char_code,
  input  logic                                  begin_literal,
  input  logic                                  end_of_input,
  input  logic                                  out_valid,
  input  logic                                  out_stall,
  input  logic                                  accepted,
  input  logic signed [ilp_pkg::VALUE_BITS-1:0] literal_value,
  input  logic [ilp_pkg::COUNT_W-1:0]           chars_used,
  input  logic [1:0]                            radix_code,
  output int                                    fail_count,
  output int                                    outstanding,
  output int                                    results_checked,
  output int                                    accepted_seen
);

  typedef enum logic [2:0] {
    SCAN_IDLE,
    SCAN_SIGN,
    SCAN_PREFIX,
    SCAN_ZERO,
    SCAN_FIRST,
    SCAN_DIGITS
  } scan_phase_t;

  localparam logic [7:0] CH_0      = "0";
  localparam logic [7:0] CH_9      = "9";
  localparam logic [7:0] CH_LA     = "a";
  localparam logic [7:0] CH_LZ     = "z";
  localparam logic [7:0] CH_UA     = "A";
  localparam logic [7:0] CH_UZ     = "Z";
  localparam logic [7:0] CH_LX     = "x";
  localparam logic [7:0] CH_LB     = "b";
  localparam logic [7:0] CH_PLUS   = "+";
  localparam logic [7:0] CH_MINUS  = "-";
  localparam logic [7:0] CH_UNDER  = "_";
  localparam logic [7:0] NOT_DIGIT = 8'hFF;
  localparam int         PRINT_CAP = 20;

  scan_phase_t                    phase;
  logic                           negative;
  ilp_pkg::radix_t                radix;
  logic [ilp_pkg::VALUE_BITS-1:0] accum;
  logic [ilp_pkg::COUNT_W-1:0]    used;
  ilp_pkg::result_t               results_due[$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (fail_count < PRINT_CAP)
      $display("[%0t] %s: got %0h, expected %0h", $time, what, got, want);
    fail_count++;
  endtask

  function automatic void count_consumed();
    if (used != '1) used = used + 1'b1;
  endfunction

  // one accepted word through the parser state
  task automatic parse_word(input logic [7:0] c, input logic b, input logic e);
    logic [7:0]                     digit;
    logic [ilp_pkg::VALUE_BITS-1:0] base;
    logic                           settled;
    logic                           finished;
    logic                           ok;
    ilp_pkg::result_t               res;
    if (c >= CH_0 && c <= CH_9) digit = c - CH_0;
    else if (c >= CH_LA && c <= CH_LZ) digit = c - CH_LA + 8'd10;
    else if (c >= CH_UA && c <= CH_UZ) digit = c - CH_UA + 8'd10;
    else digit = NOT_DIGIT;
    if (b) begin
      negative = 1'b0;
      radix    = ilp_pkg::RX_DEC;
      accum    = '0;
      used     = '0;
      phase    = SCAN_SIGN;
    end
    settled  = (phase == SCAN_IDLE);
    finished = 1'b0;
    ok       = 1'b0;
    while (!settled && !finished) begin
      case (radix)
        ilp_pkg::RX_HEX: base = 16;
        ilp_pkg::RX_BIN: base = 2;
        ilp_pkg::RX_OCT: base = 8;
        default:         base = 10;
      endcase
      case (phase)
        SCAN_SIGN: begin
          if (!e && (c == CH_PLUS || c == CH_MINUS)) begin
            negative = (c == CH_MINUS);
            count_consumed();
            settled = 1'b1;
          end
          phase = SCAN_PREFIX;
        end
        SCAN_PREFIX: begin
          if (!e && c == CH_0) begin
            count_consumed();
            phase   = SCAN_ZERO;
            settled = 1'b1;
          end else begin
            radix = ilp_pkg::RX_DEC;
            phase = SCAN_FIRST;
          end
        end
        SCAN_ZERO: begin
          if (!e && (c == CH_LX || c == CH_LB)) begin
            if (c == CH_LX) radix = ilp_pkg::RX_HEX;
            else radix = ilp_pkg::RX_BIN;
            count_consumed();
            settled = 1'b1;
          end else begin
            radix = ilp_pkg::RX_OCT;
          end
          phase = SCAN_FIRST;
        end
        SCAN_FIRST: begin
          if (!e && digit < base) begin
            accum = ilp_pkg::VALUE_BITS'(digit);
            count_consumed();
            phase   = SCAN_DIGITS;
            settled = 1'b1;
          end else begin
            // a lone zero is the only literal without digits that passes
            accum    = '0;
            ok       = (radix == ilp_pkg::RX_OCT);
            finished = 1'b1;
          end
        end
        SCAN_DIGITS: begin
          if (!e && c == CH_UNDER) begin
            count_consumed();
            settled = 1'b1;
          end else if (!e && digit < base) begin
            accum = accum * base + digit;
            count_consumed();
            settled = 1'b1;
          end else begin
            ok       = 1'b1;
            finished = 1'b1;
          end
        end
        default: begin
          phase   = SCAN_IDLE;
          settled = 1'b1;
        end
      endcase
    end
    if (finished) begin
      res.accepted      = ok;
      res.literal_value = ok ? (negative ? -accum : accum) : '0;
      res.chars_used    = used;
      res.radix_code    = radix;
      results_due.push_back(res);
      outstanding++;
      phase = SCAN_IDLE;
    end
  endtask

  always @(posedge clk) begin
    ilp_pkg::result_t want;
    if (rst) begin
      phase           = SCAN_IDLE;
      negative        = 1'b0;
      radix           = ilp_pkg::RX_DEC;
      accum           = '0;
      used            = '0;
      results_due.delete();
      fail_count      = 0;
      outstanding     = 0;
      results_checked = 0;
      accepted_seen   = 0;
    end else begin
      if ($isunknown(out_valid) || $isunknown(in_stall))
        report_mismatch("unknown handshake", {out_valid, in_stall}, 0);
      if (in_valid && !in_stall)
        parse_word(char_code, begin_literal, end_of_input);
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          report_mismatch("result with nothing expected", literal_value, 0);
        end else begin
          want = results_due.pop_front();
          outstanding--;
          results_checked++;
          if (want.accepted) accepted_seen++;
          if (accepted !== want.accepted)
            report_mismatch("accepted", accepted, want.accepted);
          if (literal_value !== want.literal_value)
            report_mismatch("literal_value", literal_value, want.literal_value);
          if (chars_used !== want.chars_used)
            report_mismatch("chars_used", chars_used, want.chars_used);
          if (radix_code !== want.radix_code)
            report_mismatch("radix_code", radix_code, want.radix_code);
        end
      end
    end
  end

endmodule

// ===== tb/integer_literal_parser_test.sv =====
// top of the integer literal parser testbench: stimulus, receiver stalls and verdict
`timescale 1ns / 100ps

module integer_literal_parser_test;

  // receiver behaviour, changed every so often
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_HALF,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  localparam int RANDOM_WORDS = 1350;

  logic                                  clk           = 1'b0;
  logic                                  rst           = 1'b1;
  logic                                  in_valid      = 1'b0;
  logic                                  in_stall;
  logic [7:0]                            char_code     = 8'h00;
  logic                                  begin_literal = 1'b0;
  logic                                  end_of_input  = 1'b0;
  logic                                  out_valid;
  logic                                  out_stall     = 1'b0;
  logic                                  accepted;
  logic signed [ilp_pkg::VALUE_BITS-1:0] literal_value;
  logic [ilp_pkg::COUNT_W-1:0]           chars_used;
  logic [1:0]                            radix_code;

  int fail_count;
  int outstanding;
  int results_checked;
  int accepted_seen;

  int          burst_left  = 0;
  int          words_sent  = 0;
  stall_mode_t stall_mode  = STALL_NONE;
  int          stall_left  = 0;
  int unsigned cycle_count = 0;

  integer_literal_parser dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .char_code     (char_code),
    .begin_literal (begin_literal),
    .end_of_input  (end_of_input),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .accepted      (accepted),
    .literal_value (literal_value),
    .chars_used    (chars_used),
    .radix_code    (radix_code)
  );

  integer_literal_parser_checker checker_inst (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .char_code       (char_code),
    .begin_literal   (begin_literal),
    .end_of_input    (end_of_input),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .accepted        (accepted),
    .literal_value   (literal_value),
    .chars_used      (chars_used),
    .radix_code      (radix_code),
    .fail_count      (fail_count),
    .outstanding     (outstanding),
    .results_checked (results_checked),
    .accepted_seen   (accepted_seen)
  );

  always #6 clk = ~clk;

  // receiver: a fresh random stall mode whenever the current one runs out,
  // so stretches with no back-pressure alternate with heavy ones
  always @(negedge clk) begin
    cycle_count++;
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    case (stall_mode)
      STALL_HALF:     out_stall = ($urandom_range(0, 1) == 1);
      STALL_HEAVY:    out_stall = ($urandom_range(0, 9) < 8);
      STALL_PERIODIC: out_stall = cycle_count[2];
      default:        out_stall = 1'b0;
    endcase
  end

  // one word onto the input channel, in bursts with random gaps between them;
  // called at a falling edge and returns at the falling edge after acceptance
  task automatic send_word(input logic [7:0] c, input logic b, input logic e);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      // now and then a long burst with no idling at all
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 12);
    end
    char_code     = c;
    begin_literal = b;
    end_of_input  = e;
    in_valid      = 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    @(negedge clk);
    burst_left--;
    words_sent++;
  endtask

  // a string of words, the first one marked as the start of a literal if asked
  task automatic send_text(input string s, input logic start);
    for (int i = 0; i < s.len(); i++)
      send_word(s[i], start && (i == 0), 1'b0);
  endtask

  // hold the sender off until every outstanding result has been delivered
  task automatic wait_for_results();
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // well-formed literal with random content, then a random way of ending it
  task automatic send_random_literal(input logic very_long);
    logic [7:0]      text[$];
    ilp_pkg::radix_t rx;
    int              base;
    int              ndig;
    int              v;
    logic [7:0]      ch;
    logic [7:0]      term;
    case ($urandom_range(0, 3))
      0:       text.push_back("+");
      1:       text.push_back("-");
      default: ;
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2: rx = ilp_pkg::RX_HEX;
      3, 4:    rx = ilp_pkg::RX_BIN;
      5, 6:    rx = ilp_pkg::RX_OCT;
      default: rx = ilp_pkg::RX_DEC;
    endcase
    case (rx)
      ilp_pkg::RX_HEX: begin text.push_back("0"); text.push_back("x"); base = 16; end
      ilp_pkg::RX_BIN: begin text.push_back("0"); text.push_back("b"); base = 2; end
      ilp_pkg::RX_OCT: begin text.push_back("0"); base = 8; end
      default:         base = 10;
    endcase
    // no digits: empty prefix fails, a lone zero passes, a bare sign fails
    if (very_long) ndig = $urandom_range(260, 300);
    else if ($urandom_range(0, 7) == 0) ndig = 0;
    else if ($urandom_range(0, 5) == 0) ndig = $urandom_range(14, 40);
    else ndig = $urandom_range(1, 10);
    for (int i = 0; i < ndig; i++) begin
      if (i > 0 && $urandom_range(0, 6) == 0) text.push_back("_");
      // keep a plain decimal literal from turning into octal
      v = (rx == ilp_pkg::RX_DEC && i == 0) ? $urandom_range(1, 9)
                                            : $urandom_range(0, base - 1);
      if (v < 10) ch = 8'("0" + v);
      else if ($urandom_range(0, 1) == 1) ch = 8'("a" + v - 10);
      else ch = 8'("A" + v - 10);
      text.push_back(ch);
    end
    for (int i = 0; i < text.size(); i++)
      send_word(text[i], i == 0, 1'b0);
    case ($urandom_range(0, 9))
      0, 1:    term = 8'h00;
      2:       term = 8'hFF;
      3:       term = 8'($urandom_range(0, 255));
      4:       term = ";";
      5:       term = ")";
      6:       term = "\n";
      default: term = " ";
    endcase
    case ($urandom_range(0, 9))
      // end of input closes the literal, the character beside it is ignored
      0, 1: send_word(8'($urandom_range(0, 255)), text.size() == 0, 1'b1);
      // left open: the next start marker abandons it
      2:    if (text.size() == 0) send_word(term, 1'b1, 1'b0);
      // a start marker with end of input right after the literal
      3:    send_word(8'($urandom_range(0, 255)), 1'b1, 1'b1);
      default: send_word(term, text.size() == 0, 1'b0);
    endcase
  endtask

  // broken sequences: fully random words with random marks
  task automatic send_noise();
    repeat ($urandom_range(1, 6))
      send_word(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                $urandom_range(0, 3) == 0);
  endtask

  initial begin
    int target;
    int lit_idx;
    logic drained_mid;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // directed words
    send_text("0b", 1'b1);              // binary prefix without digits
    send_word(8'h00, 1'b0, 1'b1);       // ... closed by end of input
    send_text("-0x", 1'b1);             // hex prefix without digits
    send_word(8'hFF, 1'b0, 1'b0);       // ... closed by the top byte
    send_text("0X", 1'b1);              // lone zero, upper-case x is not a prefix
    send_text("0_", 1'b1);              // lone zero, underscore ends it
    send_word("7", 1'b1, 1'b1);         // start marker together with end of input
    send_text("+;", 1'b1);              // sign with no digits
    send_text("12", 1'b1);              // abandoned by the next start marker
    send_text("-0xaF9 ", 1'b1);         // negative hex, mixed case
    send_text("1_0", 1'b1);             // underscore between digits
    send_word(8'hFF, 1'b0, 1'b1);
    send_text("z", 1'b0);               // no open literal: ignored
    send_text("-017", 1'b1);            // octal, closed by an out-of-range digit
    send_word("8", 1'b0, 1'b0);
    wait_for_results();

    // random part, with one drain halfway through
    target      = words_sent + RANDOM_WORDS;
    lit_idx     = 0;
    drained_mid = 1'b0;
    while (words_sent < target) begin
      if (!drained_mid && words_sent >= target - RANDOM_WORDS / 2) begin
        wait_for_results();
        drained_mid = 1'b1;
      end
      // the fourth pick is always a very long literal, for count saturation
      if (lit_idx != 3 && $urandom_range(0, 19) == 0) send_noise();
      else send_random_literal(lit_idx == 3 || $urandom_range(0, 199) == 0);
      lit_idx++;
    end

    wait_for_results();
    repeat (10) @(negedge clk);
    $display("run covered %0d character words, %0d literal results checked, %0d accepted",
             words_sent, results_checked, accepted_seen);
    $display("signs, all radices, empty prefixes, underscores, wrap, count saturation, "
             , "restarts and idle words included");
    if (fail_count == 0) begin
      $display("integer_literal_parser verification clean");
    end else begin
      $display("integer_literal_parser verification failed");
    end
    $finish;
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("timeout with %0d results still outstanding", outstanding);
    $display("integer_literal_parser verification failed");
    $finish;
  end

endmodule
